// ----- sv/tilt_kalman_filter_core_macros.svh -----
// Assertion macros shared by the tilt Kalman filter RTL.
`ifndef TILT_KALMAN_FILTER_CORE_MACROS_SVH
`define TILT_KALMAN_FILTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TKF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TKF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TKF_ASSERT(lbl, prop, msg)
`define TKF_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- sv/tkf_pkg.sv -----
// Types, constants and helper functions of the tilt Kalman filter.
package tkf_pkg;

  localparam int unsigned DW = 32;
  localparam int unsigned CW = 31;

  localparam logic [CW-1:0] APN_RST = 31'd1073742;
  localparam logic [CW-1:0] BPN_RST = 31'd3221225;
  localparam logic [CW-1:0] MN_RST  = 31'd719407022;
  localparam logic [CW-1:0] DT_RST  = 31'd5368709;
  localparam logic signed [DW-1:0] Q30_ONE = 32'sh4000_0000;

  localparam logic [3:0] LAST_PRED_STEP = 4'd4;
  localparam logic [3:0] LAST_STEP      = 4'd10;

  typedef enum logic [1:0] {
    REG_APN = 2'd0,
    REG_BPN = 2'd1,
    REG_MN  = 2'd2,
    REG_DT  = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    A_DIFF, A_PDOT, A_BB, A_BPN, A_K0, A_K1
  } a_sel_e;

  typedef enum logic [1:0] {
    B_DT, B_AA, B_AB, B_ERR
  } b_sel_e;

  typedef enum logic [2:0] {
    D_ANGLE, D_BIAS, D_AA, D_AB, D_BA, D_BB
  } dest_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_DIV, ST_DIVW, ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    a_sel_e a_sel;
    b_sel_e b_sel;
    dest_e  dest;
    logic   sub;
  } mop_t;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic       acc_en;
    logic [3:0] step;
    logic       div_start;
    logic       div_sel;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  // Multiply-accumulate program: predict steps first, then the update steps.
  // The update steps are ordered so that every operand is still the old value.
  function automatic mop_t mop_lookup(input logic [3:0] step);
    mop_t m;
    begin
      unique case (step)
        4'd0:    m = '{a_sel: A_DIFF, b_sel: B_DT,  dest: D_ANGLE, sub: 1'b0};
        4'd1:    m = '{a_sel: A_PDOT, b_sel: B_DT,  dest: D_AA,    sub: 1'b0};
        4'd2:    m = '{a_sel: A_BB,   b_sel: B_DT,  dest: D_AB,    sub: 1'b1};
        4'd3:    m = '{a_sel: A_BB,   b_sel: B_DT,  dest: D_BA,    sub: 1'b1};
        4'd4:    m = '{a_sel: A_BPN,  b_sel: B_DT,  dest: D_BB,    sub: 1'b0};
        4'd5:    m = '{a_sel: A_K1,   b_sel: B_AA,  dest: D_BA,    sub: 1'b1};
        4'd6:    m = '{a_sel: A_K1,   b_sel: B_AB,  dest: D_BB,    sub: 1'b1};
        4'd7:    m = '{a_sel: A_K0,   b_sel: B_AA,  dest: D_AA,    sub: 1'b1};
        4'd8:    m = '{a_sel: A_K0,   b_sel: B_AB,  dest: D_AB,    sub: 1'b1};
        4'd9:    m = '{a_sel: A_K1,   b_sel: B_ERR, dest: D_BIAS,  sub: 1'b0};
        4'd10:   m = '{a_sel: A_K0,   b_sel: B_ERR, dest: D_ANGLE, sub: 1'b0};
        default: m = '{a_sel: A_DIFF, b_sel: B_DT,  dest: D_ANGLE, sub: 1'b0};
      endcase
      return m;
    end
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] maxv;
    logic signed [35:0] minv;
    begin
      maxv = 36'sd2147483647;
      minv = -36'sd2147483648;
      if (v > maxv) begin
        return 32'sh7fff_ffff;
      end else if (v < minv) begin
        return 32'sh8000_0000;
      end
      return v[DW-1:0];
    end
  endfunction

endpackage

// ----- sv/tilt_kalman_filter_core.sv -----
// Top level of the two-state tilt Kalman filter (angle and gyro bias).
//
//   Channel   Signals                                   Direction
//   input     in_valid_i, in_ready_o, angle_meas_i,     sample in
//             gyro_rate_i
//   output    out_valid_o, out_ready_i, angle_est_o,    estimate out
//             rate_est_o
//   config    cfg_we_i, cfg_addr_i, cfg_wdata_i         register write
//
// Each sample runs the predict steps, the two gain divisions and the update
// steps, and no new sample is accepted until it is through; a gain that
// saturates or a zero innovation variance skips the bit-serial loop. The
// bit-serial divider (start and hand-off per gain, two gains) sets most of
// the sample time; the eleven multiply-accumulate steps on the single shared
// multiplier each run a multiply state and then an accumulate state.
// Reset loads the default noise, period and covariance values at once.
// A finished estimate waits in the output register while the next sample
// is accepted; only the next result's hand-off stalls on a full output register.
module tilt_kalman_filter_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  angle_meas_i,
  input  logic signed [31:0]  gyro_rate_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  angle_est_o,
  output logic signed [31:0]  rate_est_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [30:0]         cfg_wdata_i
);
  import tkf_pkg::*;

  // Commands flow from the sequencer to the datapath; the datapath only
  // reports back when a gain division has finished.
  cmd_t    cmd;
  status_t status;

  tkf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration registers, the filter state and
  // the result register of the output transaction.
  tkf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .angle_meas_i (angle_meas_i),
    .gyro_rate_i  (gyro_rate_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .angle_est_o  (angle_est_o),
    .rate_est_o   (rate_est_o)
  );

endmodule

// ----- sv/tkf_div.sv -----
// Bit-serial signed divider that forms one Q2.30 gain, saturated to 32 bits.
module tkf_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  num_i,
  input  logic signed [32:0]  den_i,
  output logic                done_o,
  output logic signed [31:0]  quot_o
);
  import tkf_pkg::*;

  logic [31:0] mag_n;
  logic [32:0] mag_e;
  logic        neg;
  logic        ovf;
  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_q;
  logic [30:0] quo_q;
  logic        neg_q;
  logic        nlsb_q;
  logic [32:0] den_q;
  logic signed [31:0] quot_q;
  logic [33:0] shifted;
  logic        qbit;
  logic [30:0] quo_next;
  logic [33:0] diff;

  always_comb begin
    mag_n = num_i[31] ? 32'(-num_i) : 32'(num_i);
    mag_e = den_i[32] ? 33'(-den_i) : 33'(den_i);
    neg   = num_i[31] ^ den_i[32];
    // The quotient reaches 2^31 exactly when |num| >= 2 * |den|.
    ovf   = {2'b00, mag_n} >= {mag_e, 1'b0};
    shifted  = {rem_q, (cnt_q == 5'd0) ? nlsb_q : 1'b0};
    diff     = shifted - {1'b0, den_q};
    qbit     = shifted >= {1'b0, den_q};
    quo_next = {quo_q[29:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (den_i == '0 || ovf) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, mag_n[31:1]};
      nlsb_q <= mag_n[0];
      den_q  <= mag_e;
      neg_q  <= neg;
      quo_q  <= '0;
      if (den_i == '0) begin
        quot_q <= '0;
      end else if (ovf) begin
        quot_q <= neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
    end else if (busy_q) begin
      quo_q <= quo_next;
      if (qbit) begin
        rem_q <= diff[32:0];
      end else begin
        rem_q <= shifted[32:0];
      end
      if (cnt_q == 5'd30) begin
        quot_q <= neg_q ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- sv/tkf_dp.sv -----
// Datapath: registers, state, shared multiplier, accumulator and gain divider.
module tkf_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [30:0]         cfg_wdata_i,
  input  logic signed [31:0]  angle_meas_i,
  input  logic signed [31:0]  gyro_rate_i,
  input  tkf_pkg::cmd_t       cmd_i,
  output tkf_pkg::status_t    status_o,
  output logic signed [31:0]  angle_est_o,
  output logic signed [31:0]  rate_est_o
);
  import tkf_pkg::*;

  logic [CW-1:0] apn_q, bpn_q, mn_q, dt_q;
  logic signed [DW-1:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
  logic signed [DW-1:0] meas_q, gyro_q, k0_q, k1_q;
  logic signed [DW-1:0] angle_est_q, rate_est_q;
  logic signed [63:0]   prod_q;
  logic signed [63:0]   prod_r;
  logic signed [33:0]   rmul_v;
  logic signed [DW-1:0] diff, pdot, err, opa, opb, base, acc_val;
  logic signed [35:0]   sum;
  logic signed [DW-1:0] div_num;
  logic signed [32:0]   div_den;
  logic signed [DW-1:0] div_quot;
  logic                 div_done;
  mop_t                 mop;

  always_comb begin
    diff = sat32(36'(gyro_q) - 36'(bias_q));
    pdot = sat32($signed({5'b0, apn_q}) - 36'(ab_q) - 36'(ba_q));
    err  = sat32(36'(meas_q) - 36'(angle_q));
    mop  = mop_lookup(cmd_i.step);

    case (mop.a_sel)
      A_DIFF:  opa = diff;
      A_PDOT:  opa = pdot;
      A_BB:    opa = bb_q;
      A_BPN:   opa = $signed({1'b0, bpn_q});
      A_K0:    opa = k0_q;
      A_K1:    opa = k1_q;
      default: opa = diff;
    endcase

    case (mop.b_sel)
      B_DT:    opb = $signed({1'b0, dt_q});
      B_AA:    opb = aa_q;
      B_AB:    opb = ab_q;
      B_ERR:   opb = err;
      default: opb = err;
    endcase

    case (mop.dest)
      D_ANGLE: base = angle_q;
      D_BIAS:  base = bias_q;
      D_AA:    base = aa_q;
      D_AB:    base = ab_q;
      D_BA:    base = ba_q;
      D_BB:    base = bb_q;
      default: base = angle_q;
    endcase

    // Round half up, then floor by 2^30.
    prod_r  = prod_q + 64'sd536870912;
    rmul_v  = $signed(prod_r[63:30]);
    sum     = mop.sub ? (36'(base) - 36'(rmul_v)) : (36'(base) + 36'(rmul_v));
    acc_val = sat32(sum);

    div_num = cmd_i.div_sel ? ba_q : aa_q;
    div_den = $signed({2'b00, mn_q}) + 33'(aa_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apn_q   <= APN_RST;
      bpn_q   <= BPN_RST;
      mn_q    <= MN_RST;
      dt_q    <= DT_RST;
      angle_q <= '0;
      bias_q  <= '0;
      aa_q    <= Q30_ONE;
      ab_q    <= '0;
      ba_q    <= '0;
      bb_q    <= Q30_ONE;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_addr_i))
          REG_APN: apn_q <= cfg_wdata_i;
          REG_BPN: bpn_q <= cfg_wdata_i;
          REG_MN:  mn_q  <= cfg_wdata_i;
          REG_DT:  dt_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.acc_en) begin
        case (mop.dest)
          D_ANGLE: angle_q <= acc_val;
          D_BIAS:  bias_q  <= acc_val;
          D_AA:    aa_q    <= acc_val;
          D_AB:    ab_q    <= acc_val;
          D_BA:    ba_q    <= acc_val;
          D_BB:    bb_q    <= acc_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      meas_q <= angle_meas_i;
      gyro_q <= gyro_rate_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= 64'(opa) * 64'(opb);
    end
    if (div_done) begin
      if (cmd_i.div_sel) begin
        k1_q <= div_quot;
      end else begin
        k0_q <= div_quot;
      end
    end
    if (cmd_i.out_load) begin
      angle_est_q <= angle_q;
      rate_est_q  <= diff;
    end
  end

  tkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign status_o.div_done = div_done;
  assign angle_est_o = angle_est_q;
  assign rate_est_o  = rate_est_q;

endmodule

// ----- sv/tkf_ctrl.sv -----
// Controller: sequences the predict steps, the two gain divisions and the update.
`include "tilt_kalman_filter_core_macros.svh"
module tkf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tkf_pkg::status_t status_i,
  output tkf_pkg::cmd_t    cmd_o
);
  import tkf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        div_sel_q, div_sel_d;
  logic        out_valid_q, out_valid_d;
  logic        div_done_i;

  assign div_done_i = status_i.div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      div_sel_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      div_sel_q   <= div_sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    div_sel_d = div_sel_q;
    cmd_o     = '0;
    cmd_o.step    = step_q;
    cmd_o.div_sel = div_sel_q;
    in_ready_o    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          step_d  = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 4'd1;
          if (step_q == LAST_PRED_STEP) begin
            div_sel_d = 1'b0;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done_i) begin
          if (!div_sel_q) begin
            div_sel_d = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `TKF_ASSERT(a_accept_starts, in_valid_i && in_ready_o |=> state_q == ST_MUL && step_q == '0, "accepted sample did not start the predict sequence")
  `TKF_ASSERT(a_div_after_pred, state_q == ST_ACC && step_q == LAST_PRED_STEP |=> state_q == ST_DIV, "gain division did not follow the predict steps")
  `TKF_ASSERT_NEVER(a_done_out_of_wait, div_done_i && state_q != ST_DIVW, "divider finished while no division was pending")
  `TKF_ASSERT_NEVER(a_step_range, step_q > LAST_STEP, "step counter ran past the program")

endmodule
